// ===== design/bim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_pkg: shared types and constants of the boundary importance map
// Default sizes, request and register codes, scan states and neighbor codes.
// ----------------------------------------------------------------------------
package bim_pkg;

	// default geometry
	localparam int DEF_MAX_ROWS   = 256;
	localparam int DEF_MAX_COLS   = 256;
	localparam int DEF_MAX_LEVELS = 8;

	// field widths
	localparam int LABEL_W = 8;
	localparam int IMP_W   = 3;
	localparam int CFG_W   = 9;
	localparam int CFG_AW  = 2;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_IMAGE_ROWS  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_IMAGE_COLS  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LEVEL_COUNT = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] RST_IMAGE_ROWS  = 9'd256;
	localparam logic [CFG_W-1:0] RST_IMAGE_COLS  = 9'd256;
	localparam logic [3:0]       RST_LEVEL_COUNT = 4'd7;

	// neighbor read sequence of one window position
	localparam logic [2:0] NB_UP    = 3'd1;
	localparam logic [2:0] NB_DOWN  = 3'd2;
	localparam logic [2:0] NB_LEFT  = 3'd3;
	localparam logic [2:0] NB_RIGHT = 3'd4;

	// scan sequencer states
	typedef enum logic [1:0] {
		SC_IDLE,
		SC_POS,
		SC_NB,
		SC_LAST
	} scan_state_t;

endpackage

// ===== design/boundary_importance_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_importance_map_core: label image store with importance queries
// Top level: configuration registers, request decode, label memory, scanner.
// ----------------------------------------------------------------------------
// A write item stores one label pixel in the cycle it is accepted and leaves
// busy low, so writes can follow every cycle while no scan holds busy high.
// A query outside the configured image, or with fewer than two levels,
// answers 0 on done in the cycle after it is accepted. Any other query
// raises busy and scans window positions in rings of growing city-block
// distance, stopping at the first boundary pixel: a position outside the
// image is skipped, a position inside it takes five reads through the single
// read port of the label memory plus the compare, and the result is
// registered. With L levels at most 1+2(L-1)(L-2) positions are visited; a
// query near a boundary stops early. done is high for exactly one cycle
// with importance; the receiver must take it then, as the block cannot be
// stalled.
// ----------------------------------------------------------------------------
module boundary_importance_map_core import bim_pkg::*; #(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [7:0]         row,
	input  logic [7:0]         col,
	input  logic [LABEL_W-1:0] label,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output logic               done,
	output logic [IMP_W-1:0]   importance
);

	localparam int RA = $clog2(MAX_ROWS);
	localparam int CA = $clog2(MAX_COLS);
	localparam int LW = $clog2(MAX_LEVELS + 1);
	localparam int AW = RA + CA;

	logic [CFG_W-1:0]   image_rows_q;
	logic [CFG_W-1:0]   image_cols_q;
	logic [3:0]         level_count_q;

	logic [RA:0]        nr;
	logic [CA:0]        nc;
	logic [31:0]        lv;
	logic [LW-1:0]      top;
	logic               acc;
	logic               in_img;
	logic               in_store;
	logic               wr_en;
	logic               q_go;
	logic               q_zero;
	logic [AW-1:0]      rd_addr;
	logic [LABEL_W-1:0] rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q  <= RST_IMAGE_ROWS;
			image_cols_q  <= RST_IMAGE_COLS;
			level_count_q <= RST_LEVEL_COUNT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_IMAGE_ROWS:  image_rows_q  <= cfg_wdata;
				REG_IMAGE_COLS:  image_cols_q  <= cfg_wdata;
				REG_LEVEL_COUNT: level_count_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// effective sizes and top level, saturated at the maxima
	always_comb begin
		nr = (RA+1)'((32'(image_rows_q) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
			: 32'(image_rows_q));
		nc = (CA+1)'((32'(image_cols_q) > 32'(MAX_COLS)) ? 32'(MAX_COLS)
			: 32'(image_cols_q));
		lv = (32'(level_count_q) > 32'(MAX_LEVELS)) ? 32'(MAX_LEVELS)
			: 32'(level_count_q);
		top = (lv >= 32'd2) ? LW'(lv - 32'd1) : '0;
	end

	// request decode
	always_comb begin
		acc      = start && !busy;
		in_img   = (32'(row) < 32'(nr)) && (32'(col) < 32'(nc));
		in_store = (32'(row) < 32'(MAX_ROWS)) && (32'(col) < 32'(MAX_COLS));
		wr_en    = acc && (req_type == REQ_WRITE) && in_store;
		q_go     = acc && (req_type == REQ_QUERY) && in_img && (top != '0);
		q_zero   = acc && (req_type == REQ_QUERY) && !(in_img && (top != '0));
	end

	// label image memory
	bim_ram #(
		.WIDTH (LABEL_W),
		.DEPTH (1 << AW)
	) u_label_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr ({RA'(row), CA'(col)}),
		.wdata (label),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// window scanner
	bim_scan #(
		.RA (RA),
		.CA (CA),
		.LW (LW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_go      (q_go),
		.q_zero    (q_zero),
		.q_row     (RA'(row)),
		.q_col     (CA'(col)),
		.nr        (nr),
		.nc        (nc),
		.top       (top),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.busy      (busy),
		.res_valid (done),
		.res_imp   (importance)
	);

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("result strobe while a scan is running");

	a_zero_next: assert property (@(posedge clk) disable iff (!arst_n)
		q_zero |=> (done && importance == '0))
		else $error("trivial query did not answer zero in the next cycle");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type == REQ_WRITE) |=> (!done && !busy))
		else $error("write item produced a result or started a scan");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(q_go))
		else $error("scan started without an accepted query");

endmodule

// ===== design/bim_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/bim_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_scan: window scan sequencer
// Walks window positions ring by ring in increasing city-block distance,
// reads each in-image position and its four neighbors from label memory and
// stops at the first boundary pixel or at the end of the last ring.
// ----------------------------------------------------------------------------
module bim_scan import bim_pkg::*; #(
	parameter int RA = 8,
	parameter int CA = 8,
	parameter int LW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_go,
	input  logic                 q_zero,
	input  logic [RA-1:0]        q_row,
	input  logic [CA-1:0]        q_col,
	input  logic [RA:0]          nr,
	input  logic [CA:0]          nc,
	input  logic [LW-1:0]        top,
	output logic [RA+CA-1:0]     rd_addr,
	input  logic [LABEL_W-1:0]   rd_data,
	output logic                 busy,
	output logic                 res_valid,
	output logic [IMP_W-1:0]     res_imp
);

	localparam int PW = ((RA > CA) ? RA : CA) + LW + 2;

	scan_state_t state_q, state_n;

	logic [RA-1:0]        qr_q;
	logic [CA-1:0]        qc_q;
	logic [LW-1:0]        d_q;
	logic signed [LW:0]   dr_q;
	logic                 neg_q;
	logic [RA-1:0]        pr_q;
	logic [CA-1:0]        pc_q;
	logic [2:0]           k_q;
	logic [LABEL_W-1:0]   ctr_q;
	logic                 hit_q;
	logic                 res_valid_q;
	logic [IMP_W-1:0]     res_imp_q;

	logic [LW-1:0]        adr;
	logic [LW-1:0]        dcm;
	logic signed [LW:0]   dc;
	logic signed [PW-1:0] pr_s;
	logic signed [PW-1:0] pc_s;
	logic                 pos_in;
	logic                 last_side;
	logic                 ring_end;
	logic                 search_end;
	logic                 found;
	logic                 fin;
	logic                 adv;
	logic [IMP_W-1:0]     fin_imp;
	logic [RA-1:0]        nb_r;
	logic [CA-1:0]        nb_c;

	// position of the current window step
	always_comb begin
		adr  = (dr_q < 0) ? LW'(-dr_q) : LW'(dr_q);
		dcm  = d_q - adr;
		dc   = neg_q ? -$signed({1'b0, dcm}) : $signed({1'b0, dcm});
		pr_s = $signed(PW'(qr_q)) + PW'(dr_q);
		pc_s = $signed(PW'(qc_q)) + PW'(dc);
		pos_in = (pr_s >= 0) && (pr_s < $signed(PW'(nr)))
			&& (pc_s >= 0) && (pc_s < $signed(PW'(nc)));
		last_side  = neg_q || (dcm == '0);
		ring_end   = (dr_q == $signed({1'b0, d_q}));
		search_end = ring_end && last_side && (d_q == top - LW'(1));
		found      = hit_q || (rd_data != ctr_q);
	end

	// neighbor address; a neighbor outside the image rereads the center
	always_comb begin
		nb_r = pr_q;
		nb_c = pc_q;
		case (k_q)
			NB_UP: begin
				if (pr_q != '0) nb_r = pr_q - RA'(1);
			end
			NB_DOWN: begin
				if ((RA+1)'(pr_q) + (RA+1)'(1) < nr) nb_r = pr_q + RA'(1);
			end
			NB_LEFT: begin
				if (pc_q != '0) nb_c = pc_q - CA'(1);
			end
			NB_RIGHT: begin
				if ((CA+1)'(pc_q) + (CA+1)'(1) < nc) nb_c = pc_q + CA'(1);
			end
			default: begin
				nb_r = pr_q;
				nb_c = pc_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			SC_IDLE: begin
				if (q_go) state_n = SC_POS;
			end
			SC_POS: begin
				if (pos_in) state_n = SC_NB;
				else if (search_end) state_n = SC_IDLE;
			end
			SC_NB: begin
				if (k_q == NB_RIGHT) state_n = SC_LAST;
			end
			SC_LAST: begin
				if (found || search_end) state_n = SC_IDLE;
				else state_n = SC_POS;
			end
			default: state_n = SC_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_addr = {pr_s[RA-1:0], pc_s[CA-1:0]};
		fin     = 1'b0;
		adv     = 1'b0;
		fin_imp = '0;
		case (state_q)
			SC_POS: begin
				adv = !pos_in;
				fin = !pos_in && search_end;
			end
			SC_NB: begin
				rd_addr = {nb_r, nb_c};
			end
			SC_LAST: begin
				adv = !found;
				fin = found || search_end;
				if (found) fin_imp = IMP_W'(top - d_q);
			end
			default: begin
				adv = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SC_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			res_valid_q <= fin || q_zero;
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (q_zero) res_imp_q <= '0;
		else if (fin) res_imp_q <= fin_imp;

		if (q_go) begin
			qr_q  <= q_row;
			qc_q  <= q_col;
			d_q   <= '0;
			dr_q  <= '0;
			neg_q <= 1'b0;
		end else if (adv) begin
			if (!last_side) begin
				neg_q <= 1'b1;
			end else begin
				neg_q <= 1'b0;
				if (ring_end) begin
					d_q  <= d_q + LW'(1);
					dr_q <= -$signed({1'b0, d_q + LW'(1)});
				end else begin
					dr_q <= dr_q + (LW+1)'(1);
				end
			end
		end

		// center latch and neighbor compare
		if (state_q == SC_POS) begin
			pr_q  <= pr_s[RA-1:0];
			pc_q  <= pc_s[CA-1:0];
			k_q   <= NB_UP;
			hit_q <= 1'b0;
		end else if (state_q == SC_NB) begin
			k_q <= k_q + 3'd1;
			if (k_q == NB_UP) ctr_q <= rd_data;
			else if (rd_data != ctr_q) hit_q <= 1'b1;
		end
	end

	assign busy      = (state_q != SC_IDLE);
	assign res_valid = res_valid_q;
	assign res_imp   = res_imp_q;

endmodule
